@@ rtl/ptds_pkg.sv @@
// ----------------------------------------------------------------------------
// ptds_pkg: shared types and constants for the tone period / display scan
// Holds the divider control struct, register indexes and the decode tables.
// ----------------------------------------------------------------------------
package ptds_pkg;

   localparam int DIV_W     = 24;   // dividend and quotient width
   localparam int DIV_DW    = 16;   // divisor width
   localparam int DIV_CNT_W = 5;    // step counter, holds up to DIV_W

   localparam logic [DIV_W-1:0] TIMER_CLOCK = 24'd10000000;

   // reciprocal scaling: floor(x * recip / 2**shift) is exact over the used range
   localparam int          RECIP_SHIFT = 23;
   localparam int          TENTH_SHIFT = 19;
   localparam logic [15:0] TENTH_RECIP = 16'd52429;

   localparam logic [1:0] REG_FREQ_MIN       = 2'd0;
   localparam logic [1:0] REG_FREQ_MAX       = 2'd1;
   localparam logic [1:0] REG_ADC_FULL_SCALE = 2'd2;

   typedef struct packed {
      logic                 start;
      logic [DIV_CNT_W-1:0] steps;
   } ptds_div_ctl_type;

   function automatic logic [6:0] seg_pattern(input logic [3:0] digit);
      logic [6:0] pat;
      case (digit)
         4'd0:    pat = 7'h3F;
         4'd1:    pat = 7'h06;
         4'd2:    pat = 7'h5B;
         4'd3:    pat = 7'h4F;
         4'd4:    pat = 7'h66;
         4'd5:    pat = 7'h6D;
         4'd6:    pat = 7'h7D;
         4'd7:    pat = 7'h07;
         4'd8:    pat = 7'h7F;
         4'd9:    pat = 7'h6F;
         default: pat = 7'h00;
      endcase
      return pat;
   endfunction

   // 2**RECIP_SHIFT / 10**idx, rounded up; exact for 13-bit dividends
   function automatic logic [23:0] digit_recip(input logic [1:0] idx);
      logic [23:0] p;
      case (idx)
         2'd0:    p = 24'd8388608;
         2'd1:    p = 24'd838861;
         2'd2:    p = 24'd83887;
         default: p = 24'd8389;
      endcase
      return p;
   endfunction

endpackage

@@ rtl/ptds_div.sv @@
// ----------------------------------------------------------------------------
// ptds_div: radix-2 restoring divider
// Takes a left-aligned dividend and a step count, produces one quotient bit
// per cycle; done pulses for one cycle when the quotient is valid.
// ----------------------------------------------------------------------------
module ptds_div (
   input  logic                       clock,
   input  logic                       reset,
   input  ptds_pkg::ptds_div_ctl_type ctl,
   input  logic [23:0]                dividend,
   input  logic [15:0]                divisor,
   output logic [23:0]                quotient,
   output logic                       done
);
   import ptds_pkg::*;

   logic [DIV_W-1:0]     q_ff, q_in;
   logic [DIV_DW-1:0]    r_ff, r_in;
   logic [DIV_DW-1:0]    d_ff, d_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 done_ff, done_in;
   logic [DIV_DW:0]      trial;
   logic [DIV_DW:0]      diff;
   logic                 fits;

   always_comb begin
      trial = {r_ff, q_ff[DIV_W-1]};
      diff  = trial - {1'b0, d_ff};
      fits  = (trial >= {1'b0, d_ff});

      q_in    = q_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      cnt_in  = cnt_ff;
      done_in = (cnt_ff == DIV_CNT_W'(1));
      if (ctl.start) begin
         q_in   = dividend;
         r_in   = '0;
         d_in   = divisor;
         cnt_in = ctl.steps;
      end else if (cnt_ff != '0) begin
         q_in   = {q_ff[DIV_W-2:0], fits};
         r_in   = fits ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
         cnt_in = cnt_ff - DIV_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
   end

   assign quotient = q_ff;
   assign done     = done_ff;

   a_done_after_last_step: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == DIV_CNT_W'(1)) && !ctl.start |=> done_ff)
      else $error("divider done missing after last step");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (cnt_ff == '0))
      else $error("divider done while still stepping");
   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      done_ff && (d_ff != '0) |-> (r_ff < d_ff))
      else $error("divider remainder not below divisor");

endmodule

@@ rtl/pot_tone_period_and_display_scan.sv @@
// ----------------------------------------------------------------------------
// pot_tone_period_and_display_scan: tone period mapping and display scan
// Per scan tick: drive one display digit from the stored value, map the
// converter sample to a tone frequency and derive the timer period.
//
//   channel   direction  handshake               payload
//   req       in         req_valid / req_ready   req_adc_sample
//   rsp       out        rsp_valid / rsp_ready   segments, digit_enable,
//                                                period_top, compare_level,
//                                                frequency
//   csr       in         csr_we (no wait)        csr_index, csr_wdata
//
// A request makes two passes through the single one-bit-per-cycle divider
// (17 slope steps and 24 period steps, each followed by collecting the
// quotient) between its sequencing states; the display digit and the stored
// tenths come from reciprocal multiplies. One request is in work at a time;
// req_ready is high only when idle. The result is held in an output register
// until taken; a stalled rsp side holds the sequencer in its final state.
// Synchronous active-high reset restores the register defaults and the scan.
// ----------------------------------------------------------------------------
module pot_tone_period_and_display_scan #(
   parameter int NUM_DIGITS = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [9:0]  req_adc_sample,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [6:0]  rsp_segments,
   output logic [3:0]  rsp_digit_enable,
   output logic [15:0] rsp_period_top,
   output logic [14:0] rsp_compare_level,
   output logic [15:0] rsp_frequency,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import ptds_pkg::*;

   localparam logic [2:0] NUM_DIGITS_U = 3'(NUM_DIGITS);

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_DIGQ   = 9'b000000010,
      ST_DIGR   = 9'b000000100,
      ST_SLOPE  = 9'b000001000,
      ST_MUL    = 9'b000010000,
      ST_FREQ   = 9'b000100000,
      ST_PERIOD = 9'b001000000,
      ST_SHOWN  = 9'b010000000,
      ST_DONE   = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   logic [15:0]        freq_min_ff, freq_min_in;
   logic [15:0]        freq_max_ff, freq_max_in;
   logic [9:0]         full_scale_ff, full_scale_in;
   logic [1:0]         scan_pos_ff, scan_pos_in;
   logic [12:0]        shown_ff, shown_in;

   logic [9:0]         sample_ff, sample_in;
   logic [1:0]         idx_ff, idx_in;
   logic [12:0]        quot_ff, quot_in;
   logic [3:0]         digit_ff, digit_in;
   logic signed [16:0] slope_ff, slope_in;
   logic signed [27:0] mapped_ff, mapped_in;
   logic [15:0]        freq_ff, freq_in;
   logic [15:0]        period_ff, period_in;
   logic [12:0]        shown_next_ff, shown_next_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [6:0]         rsp_segments_ff, rsp_segments_in;
   logic [3:0]         rsp_digit_enable_ff, rsp_digit_enable_in;
   logic [15:0]        rsp_period_ff, rsp_period_in;
   logic [15:0]        rsp_freq_ff, rsp_freq_in;

   ptds_div_ctl_type   div_ctl;
   logic [DIV_W-1:0]   div_dividend;
   logic [DIV_DW-1:0]  div_divisor;
   logic [DIV_W-1:0]   div_q;
   logic               div_done;

   logic [1:0]         pos_sel;
   logic [2:0]         pos_inc;
   logic signed [16:0] diff;
   logic [16:0]        diff_abs;
   logic signed [28:0] sum;
   logic [15:0]        freq_c;
   logic [35:0]        dig_prod;
   logic [15:0]        tenth_arg;
   logic [31:0]        tenth_prod;
   logic [12:0]        tenth_q;
   logic [12:0]        tens_x10;

   ptds_div u_div (
      .clock     (clock),
      .reset     (reset),
      .ctl       (div_ctl),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .quotient  (div_q),
      .done      (div_done)
   );

   always_comb begin
      // a stale position past the last digit restarts at the units
      pos_sel  = ({1'b0, scan_pos_ff} >= NUM_DIGITS_U) ? 2'd0 : scan_pos_ff;
      pos_inc  = {1'b0, pos_sel} + 3'd1;
      diff     = $signed({1'b0, freq_max_ff}) - $signed({1'b0, freq_min_ff});
      diff_abs = diff[16] ? 17'(-diff) : 17'(diff);
      sum      = 29'(mapped_ff) + $signed({13'd0, freq_min_ff});
      if (sum < 29'sd1) begin
         freq_c = 16'd1;
      end else if (sum > 29'sd65535) begin
         freq_c = 16'hFFFF;
      end else begin
         freq_c = sum[15:0];
      end
      // shown value over the digit's power of ten
      dig_prod   = 36'(shown_ff) * 36'(digit_recip(idx_ff));
      // shared divide-by-ten: digit quotient, or the frequency for display
      tenth_arg  = (state_ff == ST_SHOWN) ? freq_ff : {3'd0, quot_ff};
      tenth_prod = 32'(tenth_arg) * 32'(TENTH_RECIP);
      tenth_q    = tenth_prod[TENTH_SHIFT+12:TENTH_SHIFT];
      tens_x10   = {tenth_q[9:0], 3'd0} + {2'd0, tenth_q[9:0], 1'b0};
   end

   always_comb begin
      state_in            = state_ff;
      freq_min_in         = freq_min_ff;
      freq_max_in         = freq_max_ff;
      full_scale_in       = full_scale_ff;
      scan_pos_in         = scan_pos_ff;
      shown_in            = shown_ff;
      sample_in           = sample_ff;
      idx_in              = idx_ff;
      quot_in             = quot_ff;
      digit_in            = digit_ff;
      slope_in            = slope_ff;
      mapped_in           = mapped_ff;
      freq_in             = freq_ff;
      period_in           = period_ff;
      shown_next_in       = shown_next_ff;
      rsp_valid_in        = rsp_valid_ff & ~rsp_ready;
      rsp_segments_in     = rsp_segments_ff;
      rsp_digit_enable_in = rsp_digit_enable_ff;
      rsp_period_in       = rsp_period_ff;
      rsp_freq_in         = rsp_freq_ff;
      div_ctl.start       = 1'b0;
      div_ctl.steps       = '0;
      div_dividend        = '0;
      div_divisor         = '0;

      if (csr_we) begin
         unique case (csr_index)
            REG_FREQ_MIN:       freq_min_in   = csr_wdata;
            REG_FREQ_MAX:       freq_max_in   = csr_wdata;
            REG_ADC_FULL_SCALE: full_scale_in = csr_wdata[9:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               sample_in     = req_adc_sample;
               idx_in        = pos_sel;
               scan_pos_in   = (pos_inc >= NUM_DIGITS_U) ? 2'd0 : pos_inc[1:0];
               state_in      = ST_DIGQ;
            end
         end
         ST_DIGQ: begin
            quot_in  = dig_prod[RECIP_SHIFT+12:RECIP_SHIFT];
            state_in = ST_DIGR;
         end
         ST_DIGR: begin
            digit_in      = 4'(quot_ff - tens_x10);
            div_ctl.start = 1'b1;
            div_ctl.steps = DIV_CNT_W'(17);
            div_dividend  = {diff_abs, 7'd0};
            div_divisor   = {6'd0, full_scale_ff};
            state_in      = ST_SLOPE;
         end
         ST_SLOPE: begin
            if (div_done) begin
               // zero full scale gives a flat mapping
               if (full_scale_ff == '0) begin
                  slope_in = '0;
               end else if (diff[16]) begin
                  slope_in = -$signed(div_q[16:0]);
               end else begin
                  slope_in = $signed(div_q[16:0]);
               end
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            mapped_in = 28'(slope_ff * $signed({1'b0, sample_ff}));
            state_in  = ST_FREQ;
         end
         ST_FREQ: begin
            freq_in       = freq_c;
            div_ctl.start = 1'b1;
            div_ctl.steps = DIV_CNT_W'(24);
            div_dividend  = TIMER_CLOCK;
            div_divisor   = freq_c;
            state_in      = ST_PERIOD;
         end
         ST_PERIOD: begin
            if (div_done) begin
               // saturate instead of wrapping for low tones
               if (div_q > 24'd65536) begin
                  period_in = 16'hFFFF;
               end else begin
                  period_in = 16'(div_q - 24'd1);
               end
               state_in = ST_SHOWN;
            end
         end
         ST_SHOWN: begin
            shown_next_in = tenth_q;
            state_in      = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in        = 1'b1;
               rsp_segments_in     = seg_pattern(digit_ff);
               rsp_digit_enable_in = 4'b0001 << idx_ff;
               rsp_period_in       = period_ff;
               rsp_freq_in         = freq_ff;
               shown_in            = shown_next_ff;
               state_in            = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         freq_min_ff   <= 16'd20;
         freq_max_ff   <= 16'd20000;
         full_scale_ff <= 10'd1023;
         scan_pos_ff   <= 2'd0;
         shown_ff      <= 13'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         freq_min_ff   <= freq_min_in;
         freq_max_ff   <= freq_max_in;
         full_scale_ff <= full_scale_in;
         scan_pos_ff   <= scan_pos_in;
         shown_ff      <= shown_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      sample_ff           <= sample_in;
      idx_ff              <= idx_in;
      quot_ff             <= quot_in;
      digit_ff            <= digit_in;
      slope_ff            <= slope_in;
      mapped_ff           <= mapped_in;
      freq_ff             <= freq_in;
      period_ff           <= period_in;
      shown_next_ff       <= shown_next_in;
      rsp_segments_ff     <= rsp_segments_in;
      rsp_digit_enable_ff <= rsp_digit_enable_in;
      rsp_period_ff       <= rsp_period_in;
      rsp_freq_ff         <= rsp_freq_in;
   end

   assign req_ready         = (state_ff == ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_segments      = rsp_segments_ff;
   assign rsp_digit_enable  = rsp_digit_enable_ff;
   assign rsp_period_top    = rsp_period_ff;
   assign rsp_compare_level = rsp_period_ff[15:1];
   assign rsp_frequency     = rsp_freq_ff;

   a_digit_decimal: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |-> (digit_ff <= 4'd9))
      else $error("display digit out of decimal range");
   a_div_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_SLOPE) || (state_ff == ST_PERIOD))
      else $error("divider result arrived outside a divide state");
   a_enable_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $onehot(rsp_digit_enable_ff))
      else $error("digit enable not one-hot");
   a_freq_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_freq_ff != 16'd0))
      else $error("frequency left the clamp range");
   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      $past(req_valid && req_ready) |-> ({1'b0, scan_pos_ff} < NUM_DIGITS_U))
      else $error("scan position beyond digit count");

endmodule
